FILE: rtl/cgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgd_pkg
// shared types, constants and helpers of the greedy ctc decoder with
// running edit distance
// ----------------------------------------------------------------------------
package cgd_pkg;

    localparam int MAX_REF_LEN = 256;
    localparam int CLASS_BITS  = 16;

    localparam int REF_AW  = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_REF_LEN + 1);
    localparam int DP_DEPTH = MAX_REF_LEN + 1;

    localparam int TOK_W   = 16;
    localparam int SCORE_W = 16;
    localparam int DIST_W  = 16;
    localparam int LEN_W   = 9;
    localparam int TOT_W   = 32;
    localparam int CPF_W   = 16;

    localparam logic [1:0] MODE_REF   = 2'd0;
    localparam logic [1:0] MODE_SCORE = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic KIND_TOKEN   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [CPF_W-1:0] CPF_RESET = CPF_W'(32);

    typedef struct packed {
        logic [1:0]         mode;
        logic [TOK_W-1:0]   ref_token;
        logic [SCORE_W-1:0] score;
        logic               last_frame;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [TOK_W-1:0]   hyp_token;
        logic [DIST_W-1:0]  edit_errors;
        logic [LEN_W-1:0]   ref_length;
        logic [TOT_W-1:0]   total_errors;
        logic [TOT_W-1:0]   total_refs;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic              first_col;
        logic              mismatch;
        logic [DIST_W-1:0] up;
        logic [DIST_W-1:0] diag;
        logic [DIST_W-1:0] left;
    } t_col_in;

    function automatic logic [DIST_W-1:0] sat_inc16(input logic [DIST_W-1:0] v);
        logic [DIST_W-1:0] r;
        r = (v == '1) ? v : v + DIST_W'(1);
        return r;
    endfunction

    function automatic logic [TOT_W-1:0] sat_add32(input logic [TOT_W-1:0] a,
                                                   input logic [TOT_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOT_W] ? '1 : s[TOT_W-1:0];
    endfunction

endpackage

FILE: rtl/cgd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgd_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module cgd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/cgd_col_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgd_col_unit
// one edit distance column: saturating increments and three-way minimum
// ----------------------------------------------------------------------------
module cgd_col_unit (
    input  cgd_pkg::t_col_in                 i_col,
    output logic [cgd_pkg::DIST_W-1:0]       o_cost
);
    import cgd_pkg::*;

    logic [DIST_W-1:0] sub_c;
    logic [DIST_W-1:0] ins_c;
    logic [DIST_W-1:0] del_c;
    logic [DIST_W-1:0] m1;

    always_comb begin
        sub_c = i_col.mismatch ? sat_inc16(i_col.diag) : i_col.diag;
        ins_c = sat_inc16(i_col.up);
        del_c = sat_inc16(i_col.left);
        m1    = (ins_c < sub_c) ? ins_c : sub_c;
        if (i_col.first_col) begin
            o_cost = ins_c;
        end else begin
            o_cost = (del_c < m1) ? del_c : m1;
        end
    end

endmodule

FILE: rtl/ctc_greedy_decode_edit_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_greedy_decode_edit_distance
// greedy ctc decoder with running levenshtein distance and totals
// ----------------------------------------------------------------------------
// Reference tokens, score items, total clears and mid-frame scores are taken
// in the idle state. A frame end that yields a token walks the edit distance
// row one column per cycle through the column unit and the row memory port,
// then sends the token and, if the frame ends the utterance, the summary; a
// frame end that only ends the utterance sends the summary. Input ready is low
// during that walk and while a result waits for the output register.
// ----------------------------------------------------------------------------
module ctc_greedy_decode_edit_distance (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cgd_pkg::CPF_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cgd_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cgd_pkg::t_out_item            o_out_item
);
    import cgd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PRIME = 5'b00010,
        S_UPD   = 5'b00100,
        S_TOK   = 5'b01000,
        S_SUM   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [CPF_W-1:0]      r_cpf;
    logic [CNT_W-1:0]      r_ref_count, n_ref_count;
    logic [CPF_W-1:0]      r_cc, n_cc;
    logic [SCORE_W-1:0]    r_best_score, n_best_score;
    logic [CLASS_BITS-1:0] r_best_class, n_best_class;
    logic [CLASS_BITS-1:0] r_prev_class, n_prev_class;
    logic                  r_first, n_first;
    logic                  r_fresh, n_fresh;
    logic                  r_end, n_end;
    logic [CLASS_BITS-1:0] r_tok, n_tok;
    logic [TOT_W-1:0]      r_err_total, n_err_total;
    logic [TOT_W-1:0]      r_ref_total, n_ref_total;
    logic [CNT_W-1:0]      r_col, n_col;
    logic [DIST_W-1:0]     r_diag, n_diag;
    logic [DIST_W-1:0]     r_left, n_left;
    logic [DIST_W-1:0]     r_dist, n_dist;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic                  in_xfer;
    logic                  out_free;
    logic                  ref_we;
    logic [REF_AW-1:0]     ref_raddr;
    logic [TOK_W-1:0]      ref_rdata;
    logic                  dp_we;
    logic [CNT_W-1:0]      dp_raddr;
    logic [DIST_W-1:0]     dp_rdata;
    logic [DIST_W-1:0]     col_up;
    logic [DIST_W-1:0]     col_cost;
    logic [DIST_W-1:0]     cur_dist;
    t_col_in               col_in;
    logic                  take_best;
    logic [CLASS_BITS-1:0] cls;
    logic                  emit;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign ref_we    = in_xfer && (i_in_item.mode == MODE_REF) && r_first
                       && (r_cc == '0) && (r_ref_count < CNT_W'(MAX_REF_LEN));
    assign ref_raddr = r_col[REF_AW-1:0];
    assign dp_we     = (r_state == S_UPD);
    assign dp_raddr  = (r_state == S_UPD && r_col != r_ref_count) ?
                       r_col + CNT_W'(1) : ((r_state == S_UPD) ? r_col : '0);

    cgd_ram #(.WIDTH(TOK_W), .DEPTH(MAX_REF_LEN)) u_ref_ram (
        .i_clk  (i_clk),
        .i_we   (ref_we),
        .i_waddr(r_ref_count[REF_AW-1:0]),
        .i_wdata(i_in_item.ref_token),
        .i_raddr(ref_raddr),
        .o_rdata(ref_rdata)
    );

    cgd_ram #(.WIDTH(DIST_W), .DEPTH(DP_DEPTH)) u_dp_ram (
        .i_clk  (i_clk),
        .i_we   (dp_we),
        .i_waddr(r_col),
        .i_wdata(col_cost),
        .i_raddr(dp_raddr),
        .o_rdata(dp_rdata)
    );

    assign col_up = r_fresh ? DIST_W'(r_col) : dp_rdata;

    always_comb begin
        col_in.first_col = (r_col == '0);
        col_in.mismatch  = (ref_rdata != TOK_W'(r_tok));
        col_in.up        = col_up;
        col_in.diag      = r_diag;
        col_in.left      = r_left;
    end

    cgd_col_unit u_col (
        .i_col (col_in),
        .o_cost(col_cost)
    );

    assign cur_dist  = r_fresh ? DIST_W'(r_ref_count) : r_dist;
    assign take_best = (r_cc == '0) || (i_in_item.score > r_best_score);
    assign cls       = take_best ? r_cc[CLASS_BITS-1:0] : r_best_class;
    assign emit      = (r_first || cls != r_prev_class) && (cls != '0);

    always_comb begin
        n_state      = r_state;
        n_ref_count  = r_ref_count;
        n_cc         = r_cc;
        n_best_score = r_best_score;
        n_best_class = r_best_class;
        n_prev_class = r_prev_class;
        n_first      = r_first;
        n_fresh      = r_fresh;
        n_end        = r_end;
        n_tok        = r_tok;
        n_err_total  = r_err_total;
        n_ref_total  = r_ref_total;
        n_col        = r_col;
        n_diag       = r_diag;
        n_left       = r_left;
        n_dist       = r_dist;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_in_item.mode)
                        MODE_REF: begin
                            if (ref_we) begin
                                n_ref_count = r_ref_count + CNT_W'(1);
                            end
                        end
                        MODE_CLEAR: begin
                            n_err_total = '0;
                            n_ref_total = '0;
                        end
                        MODE_SCORE: begin
                            if (take_best) begin
                                n_best_score = i_in_item.score;
                                n_best_class = r_cc[CLASS_BITS-1:0];
                            end
                            if (({1'b0, r_cc} + (CPF_W+1)'(1)) < {1'b0, r_cpf}) begin
                                n_cc = r_cc + CPF_W'(1);
                            end else begin
                                n_cc         = '0;
                                n_prev_class = cls;
                                n_first      = 1'b0;
                                n_end        = i_in_item.last_frame;
                                n_tok        = cls;
                                n_col        = '0;
                                if (emit) begin
                                    n_state = S_PRIME;
                                end else if (i_in_item.last_frame) begin
                                    n_state = S_SUM;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PRIME: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_diag = col_up;
                n_left = col_cost;
                if (r_col == r_ref_count) begin
                    n_dist  = col_cost;
                    n_fresh = 1'b0;
                    n_state = S_TOK;
                end else begin
                    n_col = r_col + CNT_W'(1);
                end
            end
            S_TOK: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.kind         = KIND_TOKEN;
                    n_out.hyp_token    = TOK_W'(r_tok);
                    n_out.edit_errors  = r_dist;
                    n_out.ref_length   = LEN_W'(r_ref_count);
                    n_out.total_errors = r_err_total;
                    n_out.total_refs   = r_ref_total;
                    n_out.last         = !r_end;
                    n_state            = r_end ? S_SUM : S_IDLE;
                end
            end
            S_SUM: begin
                if (out_free) begin
                    n_err_total        = sat_add32(r_err_total, TOT_W'(cur_dist));
                    n_ref_total        = sat_add32(r_ref_total, TOT_W'(r_ref_count));
                    n_out_valid        = 1'b1;
                    n_out.kind         = KIND_SUMMARY;
                    n_out.hyp_token    = '0;
                    n_out.edit_errors  = cur_dist;
                    n_out.ref_length   = LEN_W'(r_ref_count);
                    n_out.total_errors = n_err_total;
                    n_out.total_refs   = n_ref_total;
                    n_out.last         = 1'b1;
                    n_ref_count        = '0;
                    n_prev_class       = '0;
                    n_first            = 1'b1;
                    n_fresh            = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cpf        <= CPF_RESET;
            r_ref_count  <= '0;
            r_cc         <= '0;
            r_prev_class <= '0;
            r_first      <= 1'b1;
            r_fresh      <= 1'b1;
            r_end        <= 1'b0;
            r_err_total  <= '0;
            r_ref_total  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_valid) begin
                r_cpf <= i_cfg_data;
            end
            r_ref_count  <= n_ref_count;
            r_cc         <= n_cc;
            r_prev_class <= n_prev_class;
            r_first      <= n_first;
            r_fresh      <= n_fresh;
            r_end        <= n_end;
            r_err_total  <= n_err_total;
            r_ref_total  <= n_ref_total;
            r_out_valid  <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_best_score <= n_best_score;
        r_best_class <= n_best_class;
        r_tok        <= n_tok;
        r_col        <= n_col;
        r_diag       <= n_diag;
        r_left       <= n_left;
        r_dist       <= n_dist;
        r_out        <= n_out;
    end

endmodule

FILE: dv/tb_ctc_greedy_decode_edit_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ctc_greedy_decode_edit_distance
// self-checking bench for the greedy ctc decoder with running edit distance.
// a bit-accurate predictor tracks the reference store, the distance row, the
// frame argmax and the totals; every result transfer is compared field by
// field with the oldest prediction. directed tests cover edit operations,
// ties, ignored items, frame sizes 0 to 65535 and reference overflow, then
// random utterances run under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_ctc_greedy_decode_edit_distance;
    import cgd_pkg::*;

    localparam logic [1:0]       MODE_UNUSED  = 2'd3;
    localparam logic [TOK_W-1:0] BLANK_CLASS  = '0;
    localparam int               CYCLE_LIMIT  = 2_000_000;
    localparam int               DRAIN_CYCLES = 300;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLOW} t_rx_style;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CPF_W-1:0]   i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_item           i_in_item;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_item          o_out_item;

    ctc_greedy_decode_edit_distance dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // decoder state as predicted
    logic [TOK_W-1:0]   ref_mem [MAX_REF_LEN];
    int                 ref_cnt;
    logic [DIST_W-1:0]  row [DP_DEPTH];
    logic [CPF_W-1:0]   cls_cnt;
    logic [CPF_W-1:0]   cpf;
    logic [SCORE_W-1:0] best_sc;
    logic [TOK_W-1:0]   best_cls;
    logic [TOK_W-1:0]   prev_cls;
    logic               first_frm;
    logic [TOT_W-1:0]   err_tot;
    logic [TOT_W-1:0]   refs_tot;

    t_out_item pending_results[$];

    int     mismatch_count = 0;
    int     items_sent     = 0;
    int     token_count    = 0;
    int     summary_count  = 0;
    int     cycle_count    = 0;
    int     burst_left     = 0;
    int     hold_left      = 0;
    bit     gaps_on        = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [DIST_W-1:0] bump(input logic [DIST_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [TOT_W-1:0] add_sat32(input logic [TOT_W-1:0] a,
                                                   input logic [TOT_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOT_W] ? '1 : s[TOT_W-1:0];
    endfunction

    function automatic t_out_item expected_result(input logic kind,
                                                  input logic [TOK_W-1:0] tok,
                                                  input logic lst);
        t_out_item r;
        r.kind         = kind;
        r.hyp_token    = tok;
        r.edit_errors  = row[ref_cnt];
        r.ref_length   = LEN_W'(ref_cnt);
        r.total_errors = err_tot;
        r.total_refs   = refs_tot;
        r.last         = lst;
        return r;
    endfunction

    // append a predicted result behind the ones still outstanding
    task automatic queue_result(input t_out_item r);
        pending_results = {pending_results, r};
    endtask

    // one levenshtein row step for a new hypothesis token
    task automatic advance_row(input logic [TOK_W-1:0] tok);
        logic [DIST_W-1:0] diag;
        logic [DIST_W-1:0] up;
        logic [DIST_W-1:0] cand;
        diag   = row[0];
        row[0] = bump(row[0]);
        for (int j = 1; j <= ref_cnt; j++) begin
            up   = row[j];
            cand = (ref_mem[j-1] != tok) ? bump(diag) : diag;
            if (bump(up) < cand) cand = bump(up);
            if (bump(row[j-1]) < cand) cand = bump(row[j-1]);
            row[j] = cand;
            diag   = up;
        end
    endtask

    task automatic predict_item(input t_in_item it);
        logic             emit;
        logic [TOK_W-1:0] cls;
        case (it.mode)
            MODE_REF: begin
                if (first_frm && cls_cnt == '0 && ref_cnt < MAX_REF_LEN) begin
                    ref_mem[ref_cnt] = it.ref_token;
                    ref_cnt++;
                end
            end
            MODE_CLEAR: begin
                err_tot  = '0;
                refs_tot = '0;
            end
            MODE_SCORE: begin
                if (first_frm && cls_cnt == '0) begin
                    for (int j = 0; j < DP_DEPTH; j++) row[j] = DIST_W'(j);
                end
                if (cls_cnt == '0 || it.score > best_sc) begin
                    best_sc  = it.score;
                    best_cls = cls_cnt;
                end
                if (int'(cls_cnt) + 1 < int'(cpf)) begin
                    cls_cnt++;
                end else begin
                    cls       = best_cls;
                    cls_cnt   = '0;
                    emit      = (first_frm || cls != prev_cls) && cls != BLANK_CLASS;
                    prev_cls  = cls;
                    first_frm = 1'b0;
                    if (emit) begin
                        advance_row(cls);
                        queue_result(expected_result(KIND_TOKEN, cls, !it.last_frame));
                    end
                    if (it.last_frame) begin
                        err_tot  = add_sat32(err_tot, TOT_W'(row[ref_cnt]));
                        refs_tot = add_sat32(refs_tot, TOT_W'(ref_cnt));
                        queue_result(expected_result(KIND_SUMMARY, '0, 1'b1));
                        ref_cnt   = 0;
                        prev_cls  = BLANK_CLASS;
                        first_frm = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: %h", o_out_item);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, o_out_item.kind);
                check_field("hyp_token", want.hyp_token, o_out_item.hyp_token);
                check_field("edit_errors", want.edit_errors, o_out_item.edit_errors);
                check_field("ref_length", want.ref_length, o_out_item.ref_length);
                check_field("total_errors", want.total_errors, o_out_item.total_errors);
                check_field("total_refs", want.total_refs, o_out_item.total_refs);
                check_field("last", want.last, o_out_item.last);
                if (want.kind == KIND_TOKEN) token_count++;
                else summary_count++;
            end
        end
    end

    // output side: changing stall styles plus a long hold-off on request
    initial begin
        t_rx_style rx_style;
        int        rx_left;
        rx_style    = RX_ALWAYS;
        rx_left     = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_style = t_rx_style'($urandom_range(0, 3));
                    rx_left  = $urandom_range(32, 300);
                end
                rx_left--;
                case (rx_style)
                    RX_ALWAYS:  i_out_ready <= 1'b1;
                    RX_RANDOM:  i_out_ready <= ($urandom_range(0, 99) < 70);
                    RX_PATTERN: i_out_ready <= (rx_left % 8 >= 3);
                    default:    i_out_ready <= ($urandom_range(0, 99) < 20);
                endcase
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic offer_item(input logic [1:0] mode, input logic [TOK_W-1:0] tok,
                              input logic [SCORE_W-1:0] sc, input logic lf);
        t_in_item it;
        it.mode       = mode;
        it.ref_token  = tok;
        it.score      = sc;
        it.last_frame = lf;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_item(it);
        items_sent++;
        @(negedge i_clk);
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        pause_until_drained();
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_cpf(input logic [CPF_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cpf = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // one frame whose argmax is win; with tie, classes from win upward share the top
    task automatic send_frame(input int win, input bit tie, input bit end_utt);
        logic [SCORE_W-1:0] s;
        logic               lf;
        for (int c = 0; c < int'(cpf); c++) begin
            if (tie)
                s = (c >= win) ? '1 : SCORE_W'($urandom_range(0, 16'hFFFE));
            else if (c == win)
                s = SCORE_W'($urandom_range(16'hC000, 16'hFFFF));
            else
                s = SCORE_W'($urandom_range(0, 16'hBFFF));
            lf = (c == int'(cpf) - 1) ? end_utt : ($urandom_range(0, 19) == 0);
            offer_item(MODE_SCORE, TOK_W'($urandom), s, lf);
        end
    endtask

    task automatic gen_utterance(input int max_frames);
        int n_refs;
        int n_frames;
        int win;
        int pick;
        if ($urandom_range(0, 15) == 0)
            offer_item(MODE_CLEAR, TOK_W'($urandom), SCORE_W'($urandom),
                       1'($urandom_range(0, 1)));
        n_refs = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                             : $urandom_range(0, 8);
        repeat (n_refs) begin
            offer_item(MODE_REF,
                       ($urandom_range(0, 3) == 0) ? TOK_W'($urandom)
                                                   : TOK_W'($urandom_range(0, int'(cpf) - 1)),
                       SCORE_W'($urandom), ($urandom_range(0, 9) == 0));
        end
        n_frames = $urandom_range(1, max_frames);
        win      = 0;
        for (int f = 0; f < n_frames; f++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                offer_item(MODE_UNUSED, TOK_W'($urandom), SCORE_W'($urandom),
                           1'($urandom_range(0, 1)));
            else if (pick < 8)
                offer_item(MODE_REF, TOK_W'($urandom), SCORE_W'($urandom), 1'b0);
            else if (pick < 10)
                offer_item(MODE_CLEAR, TOK_W'($urandom), SCORE_W'($urandom), 1'b0);
            else if (pick < 13)
                pause_until_drained();
            // otherwise repeat the last class
            if ($urandom_range(0, 9) < 6) win = $urandom_range(0, int'(cpf) - 1);
            send_frame(win, ($urandom_range(0, 9) == 0), f == n_frames - 1);
        end
    endtask

    task automatic test_reset_frame_size();
        repeat (2) gen_utterance(3);
    endtask

    task automatic test_edit_operations();
        wait_idle();
        write_cpf(CPF_W'(3));
        offer_item(MODE_REF, TOK_W'(1), '0, 1'b0);
        offer_item(MODE_REF, TOK_W'(2), '0, 1'b1);
        offer_item(MODE_REF, TOK_W'(1), '0, 1'b0);
        send_frame(1, 1'b0, 1'b0);
        send_frame(1, 1'b0, 1'b0);
        send_frame(0, 1'b1, 1'b0);
        send_frame(1, 1'b0, 1'b0);
        send_frame(2, 1'b0, 1'b0);
        send_frame(1, 1'b1, 1'b0);
        send_frame(2, 1'b0, 1'b1);
    endtask

    task automatic test_ignored_items();
        offer_item(MODE_UNUSED, '1, '1, 1'b1);
        offer_item(MODE_REF, TOK_W'(2), '0, 1'b0);
        offer_item(MODE_SCORE, '0, SCORE_W'(100), 1'b1);
        offer_item(MODE_REF, TOK_W'(7), '0, 1'b0);
        offer_item(MODE_SCORE, '0, SCORE_W'(300), 1'b0);
        offer_item(MODE_SCORE, '0, SCORE_W'(200), 1'b0);
        offer_item(MODE_REF, TOK_W'(9), '0, 1'b1);
        offer_item(MODE_CLEAR, '0, '0, 1'b1);
        send_frame(2, 1'b0, 1'b1);
    endtask

    task automatic test_field_extremes();
        wait_idle();
        write_cpf(CPF_W'(2));
        offer_item(MODE_REF, '0, '1, 1'b0);
        offer_item(MODE_REF, '1, '0, 1'b0);
        offer_item(MODE_SCORE, '1, '0, 1'b0);
        offer_item(MODE_SCORE, '1, '1, 1'b0);
        offer_item(MODE_SCORE, '0, '1, 1'b0);
        offer_item(MODE_SCORE, '0, '1, 1'b0);
        offer_item(MODE_SCORE, '0, '0, 1'b0);
        offer_item(MODE_SCORE, '0, '0, 1'b0);
        offer_item(MODE_SCORE, '0, '0, 1'b0);
        offer_item(MODE_SCORE, '0, '1, 1'b1);
        send_frame(1, 1'b0, 1'b1);
        offer_item(MODE_CLEAR, '1, '1, 1'b0);
    endtask

    task automatic test_short_frames();
        wait_idle();
        write_cpf('0);
        offer_item(MODE_REF, TOK_W'(5), '0, 1'b0);
        offer_item(MODE_SCORE, '0, SCORE_W'($urandom), 1'b0);
        offer_item(MODE_SCORE, '0, '1, 1'b1);
        wait_idle();
        write_cpf(CPF_W'(1));
        offer_item(MODE_REF, TOK_W'(5), '0, 1'b0);
        offer_item(MODE_SCORE, '0, '1, 1'b0);
        offer_item(MODE_SCORE, '0, SCORE_W'($urandom), 1'b1);
    endtask

    task automatic test_ref_overflow();
        wait_idle();
        write_cpf(CPF_W'(2));
        repeat (MAX_REF_LEN + 4)
            offer_item(MODE_REF, TOK_W'($urandom_range(0, 1)), '0, 1'b0);
        send_frame(1, 1'b0, 1'b0);
        send_frame(0, 1'b0, 1'b0);
        send_frame(1, 1'b0, 1'b0);
        send_frame(1, 1'b0, 1'b1);
    endtask

    // widest frame size keeps the frame open, then a smaller size closes it
    task automatic test_wide_frame();
        wait_idle();
        write_cpf('1);
        gaps_on = 1'b0;
        offer_item(MODE_REF, TOK_W'(16'hFFFE), '0, 1'b0);
        offer_item(MODE_REF, '1, '0, 1'b0);
        for (int c = 0; c < 6; c++)
            offer_item(MODE_SCORE, '0, SCORE_W'(c * 1000), 1'b1);
        wait_idle();
        write_cpf(CPF_W'(7));
        offer_item(MODE_SCORE, '0, SCORE_W'(100), 1'b1);
        gaps_on = 1'b1;
    endtask

    task automatic test_stalled_output();
        wait_idle();
        write_cpf(CPF_W'(4));
        gaps_on = 1'b0;
        offer_item(MODE_REF, TOK_W'(1), '0, 1'b0);
        offer_item(MODE_REF, TOK_W'(2), '0, 1'b0);
        offer_item(MODE_REF, TOK_W'(3), '0, 1'b0);
        hold_left = 400;
        for (int f = 0; f < 16; f++) send_frame(1 + f % 3, 1'b0, f == 15);
        pause_until_drained();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int sizes[6] = '{2, 3, 5, 8, 17, 2};
        int goal;
        foreach (sizes[k]) begin
            wait_idle();
            write_cpf(CPF_W'(sizes[k]));
            gaps_on = (k % 3 != 2);
            goal    = items_sent + 25;
            while (items_sent < goal) begin
                if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(40, 160);
                gen_utterance(6);
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        cpf         = CPF_RESET;
        ref_cnt     = 0;
        cls_cnt     = '0;
        best_sc     = '0;
        best_cls    = '0;
        prev_cls    = BLANK_CLASS;
        first_frm   = 1'b1;
        err_tot     = '0;
        refs_tot    = '0;
        for (int j = 0; j < DP_DEPTH; j++) row[j] = DIST_W'(j);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_frame_size();
        test_edit_operations();
        test_ignored_items();
        test_field_extremes();
        test_short_frames();
        test_ref_overflow();
        test_wide_frame();
        test_stalled_output();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("covered %0d input transfers, %0d hypothesis tokens, %0d utterance summaries",
                 items_sent, token_count, summary_count);
        $display("frame sizes 0 to 65535, reference overflow, output hold-off, sender pauses");
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
